// ----- rtl/core/edfs_pkg.sv -----
// shared types, constants and helper functions for the edf task scheduler
package edfs_pkg;

	localparam int MAX_TASKS  = 16;
	localparam int GROUPS     = 4;
	localparam int GROUP_SIZE = MAX_TASKS / GROUPS;
	localparam int TASK_W     = 4;
	localparam int TIME_W     = 32;
	localparam int EXEC_W     = 16;
	localparam int JOBS_W     = 8;
	localparam int COUNT_W    = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [COUNT_W-1:0] TASK_COUNT_RST    = 5'd1;
	localparam logic [JOBS_W-1:0]  JOBS_PER_TASK_RST = 8'd2;
	localparam logic [JOBS_W-1:0]  JOBS_MAX          = 8'hFF;

	localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_JOBS_PER_TASK = 1'd1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		logic              valid;
		logic [TASK_W-1:0] idx;
		logic [TIME_W-1:0] dl;
	} cand_t;

	typedef struct packed {
		logic capture;
		logic search;
		logic pick;
		logic apply;
	} dp_cmd_t;

	typedef struct packed {
		logic op_load;
	} dp_sts_t;

	// earlier deadline wins, lower index on a tie
	function automatic cand_t cand_min(cand_t a, cand_t b);
		if (a.valid && (!b.valid || a.dl <= b.dl)) begin
			return a;
		end
		return b;
	endfunction

	function automatic logic [TIME_W-1:0] sat_add_time(logic [TIME_W-1:0] a,
		logic [EXEC_W-1:0] b);
		logic [TIME_W:0] s;
		s = (TIME_W+1)'(a) + (TIME_W+1)'(b);
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage

// ----- rtl/core/edfs_ctrl.sv -----
// sequencing state machine for the edf task scheduler
module edfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  edfs_pkg::dp_sts_t sts,
	output edfs_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_PICK,
		ST_APPLY
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   apply_fire;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign apply_fire = (state_q == ST_APPLY) && (!out_valid_q || out_ready);

	always_comb begin
		cmd         = '0;
		cmd.capture = in_valid && (state_q == ST_IDLE);
		cmd.search  = (state_q == ST_SEARCH);
		cmd.pick    = (state_q == ST_PICK);
		cmd.apply   = apply_fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (apply_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					state_q <= sts.op_load ? ST_APPLY : ST_PICK;
				end
				ST_PICK: begin
					state_q <= ST_APPLY;
				end
				ST_APPLY: begin
					if (apply_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_apply_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> (!out_valid_q || out_ready))
		else $error("result written over an untaken one");

	a_rise_from_apply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_APPLY))
		else $error("result shown outside apply");

	a_capture_idle_only: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == ST_SEARCH))
		else $error("transfer did not start a search");

endmodule

// ----- rtl/core/edfs_dpath.sv -----
// task table, deadline search and update datapath for the edf task scheduler
module edfs_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  edfs_pkg::dp_cmd_t                   cmd,
	output edfs_pkg::dp_sts_t                   sts,
	input  logic                                operation,
	input  logic [edfs_pkg::TASK_W-1:0]         task_index,
	input  logic [edfs_pkg::EXEC_W-1:0]         exec_time,
	input  logic [edfs_pkg::EXEC_W-1:0]         period,
	input  logic                                cfg_we,
	input  logic [edfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [edfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	output logic [edfs_pkg::TIME_W-1:0]         slot_time,
	output logic [edfs_pkg::TASK_W-1:0]         granted_task,
	output logic                                idle,
	output logic                                job_complete,
	output logic                                all_finished
);

	// configuration
	logic [edfs_pkg::COUNT_W-1:0] task_count_q;
	logic [edfs_pkg::JOBS_W-1:0]  jobs_per_task_q;

	// captured item
	logic                         op_q;
	logic [edfs_pkg::TASK_W-1:0]  idx_q;
	logic [edfs_pkg::EXEC_W-1:0]  exec_q;
	logic [edfs_pkg::EXEC_W-1:0]  period_q;

	// task table
	logic [edfs_pkg::EXEC_W-1:0] task_exec_q    [edfs_pkg::MAX_TASKS];
	logic [edfs_pkg::EXEC_W-1:0] task_period_q  [edfs_pkg::MAX_TASKS];
	logic [edfs_pkg::EXEC_W-1:0] units_left_q   [edfs_pkg::MAX_TASKS];
	logic [edfs_pkg::TIME_W-1:0] release_time_q [edfs_pkg::MAX_TASKS];
	logic [edfs_pkg::TIME_W-1:0] abs_deadline_q [edfs_pkg::MAX_TASKS];
	logic [edfs_pkg::JOBS_W-1:0] jobs_served_q  [edfs_pkg::MAX_TASKS];

	logic [edfs_pkg::TIME_W-1:0] now_q;
	logic [edfs_pkg::TASK_W-1:0] cur_task_q;
	logic                        cur_valid_q;
	logic [edfs_pkg::TIME_W-1:0] cur_dl_q;

	// search pipeline
	logic [edfs_pkg::MAX_TASKS-1:0] ready_s1;
	edfs_pkg::cand_t                group_s1 [edfs_pkg::GROUPS];
	logic                           all_done_s1;
	logic                           grant_s2;
	logic [edfs_pkg::TASK_W-1:0]    pick_idx_s2;

	// result
	logic [edfs_pkg::TIME_W-1:0] slot_time_q;
	logic [edfs_pkg::TASK_W-1:0] granted_q;
	logic                        idle_q;
	logic                        job_complete_q;
	logic                        all_finished_q;

	logic [edfs_pkg::MAX_TASKS-1:0] in_use;
	logic [edfs_pkg::MAX_TASKS-1:0] ready;
	logic [edfs_pkg::MAX_TASKS-1:0] done;
	logic [edfs_pkg::MAX_TASKS-1:0] done_next;
	edfs_pkg::cand_t                cand       [edfs_pkg::MAX_TASKS];
	edfs_pkg::cand_t                group_min  [edfs_pkg::GROUPS];
	edfs_pkg::cand_t                final_min;
	logic                           keep_cur;
	logic                           is_load;

	logic [edfs_pkg::EXEC_W-1:0] sel_exec;
	logic [edfs_pkg::EXEC_W-1:0] sel_period;
	logic [edfs_pkg::EXEC_W-1:0] sel_units;
	logic [edfs_pkg::TIME_W-1:0] sel_release;
	logic [edfs_pkg::TIME_W-1:0] sel_dl;
	logic [edfs_pkg::JOBS_W-1:0] sel_jobs;
	logic [edfs_pkg::EXEC_W-1:0] units_dec;
	logic                        job_end;
	logic [edfs_pkg::JOBS_W-1:0] jobs_inc;
	logic                        more_jobs;
	logic [edfs_pkg::TIME_W-1:0] now_inc;

	assign is_load     = (op_q == edfs_pkg::OP_LOAD);
	assign sts.op_load = is_load;

	always_comb begin
		for (int i = 0; i < edfs_pkg::MAX_TASKS; i++) begin
			in_use[i] = edfs_pkg::COUNT_W'(i) < task_count_q;
			ready[i]  = in_use[i] && (now_q >= release_time_q[i])
				&& (units_left_q[i] != '0) && (jobs_served_q[i] < jobs_per_task_q);
			done[i]   = !in_use[i] || (jobs_served_q[i] >= jobs_per_task_q);
			cand[i].valid = ready[i];
			cand[i].idx   = edfs_pkg::TASK_W'(i);
			cand[i].dl    = abs_deadline_q[i];
		end
		for (int g = 0; g < edfs_pkg::GROUPS; g++) begin
			group_min[g] = edfs_pkg::cand_min(
				edfs_pkg::cand_min(cand[g*edfs_pkg::GROUP_SIZE],
					cand[g*edfs_pkg::GROUP_SIZE+1]),
				edfs_pkg::cand_min(cand[g*edfs_pkg::GROUP_SIZE+2],
					cand[g*edfs_pkg::GROUP_SIZE+3]));
		end
	end

	assign final_min = edfs_pkg::cand_min(edfs_pkg::cand_min(group_s1[0], group_s1[1]),
		edfs_pkg::cand_min(group_s1[2], group_s1[3]));
	assign keep_cur  = cur_valid_q && ready_s1[cur_task_q] && !(final_min.dl < cur_dl_q);

	// granted task entry
	assign sel_exec    = task_exec_q[pick_idx_s2];
	assign sel_period  = task_period_q[pick_idx_s2];
	assign sel_units   = units_left_q[pick_idx_s2];
	assign sel_release = release_time_q[pick_idx_s2];
	assign sel_dl      = abs_deadline_q[pick_idx_s2];
	assign sel_jobs    = jobs_served_q[pick_idx_s2];
	assign units_dec   = sel_units - edfs_pkg::EXEC_W'(1);
	assign job_end     = (units_dec == '0);
	assign jobs_inc    = (sel_jobs == edfs_pkg::JOBS_MAX) ? sel_jobs
		: sel_jobs + edfs_pkg::JOBS_W'(1);
	assign more_jobs   = jobs_inc < jobs_per_task_q;
	assign now_inc     = edfs_pkg::sat_add_time(now_q, edfs_pkg::EXEC_W'(1));

	always_comb begin
		done_next = done;
		if (is_load) begin
			done_next[idx_q] = !in_use[idx_q] || (jobs_per_task_q == '0);
		end else if (grant_s2 && job_end) begin
			done_next[pick_idx_s2] = !more_jobs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q    <= edfs_pkg::TASK_COUNT_RST;
			jobs_per_task_q <= edfs_pkg::JOBS_PER_TASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				edfs_pkg::REG_TASK_COUNT: begin
					task_count_q <= cfg_wdata[edfs_pkg::COUNT_W-1:0];
				end
				edfs_pkg::REG_JOBS_PER_TASK: begin
					jobs_per_task_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= operation;
			idx_q    <= task_index;
			exec_q   <= exec_time;
			period_q <= period;
		end
		if (cmd.search) begin
			ready_s1    <= ready;
			all_done_s1 <= &done;
			for (int g = 0; g < edfs_pkg::GROUPS; g++) begin
				group_s1[g] <= group_min[g];
			end
		end
		if (cmd.pick) begin
			grant_s2    <= !all_done_s1 && (keep_cur || final_min.valid);
			pick_idx_s2 <= keep_cur ? cur_task_q : final_min.idx;
		end
		if (cmd.apply) begin
			all_finished_q <= &done_next;
			if (is_load) begin
				slot_time_q    <= '0;
				granted_q      <= '0;
				idle_q         <= 1'b0;
				job_complete_q <= 1'b0;
			end else begin
				slot_time_q    <= now_q;
				granted_q      <= grant_s2 ? pick_idx_s2 : '0;
				idle_q         <= !grant_s2;
				job_complete_q <= grant_s2 && job_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < edfs_pkg::MAX_TASKS; i++) begin
				task_exec_q[i]    <= '0;
				task_period_q[i]  <= '0;
				units_left_q[i]   <= '0;
				release_time_q[i] <= '0;
				abs_deadline_q[i] <= '0;
				jobs_served_q[i]  <= '0;
			end
			now_q       <= '0;
			cur_task_q  <= '0;
			cur_valid_q <= 1'b0;
			cur_dl_q    <= '0;
		end else if (cmd.apply) begin
			if (is_load) begin
				task_exec_q[idx_q]    <= exec_q;
				task_period_q[idx_q]  <= period_q;
				units_left_q[idx_q]   <= exec_q;
				release_time_q[idx_q] <= '0;
				abs_deadline_q[idx_q] <= edfs_pkg::TIME_W'(period_q);
				jobs_served_q[idx_q]  <= '0;
				now_q                 <= '0;
				cur_valid_q           <= 1'b0;
			end else if (grant_s2) begin
				now_q <= now_inc;
				if (job_end) begin
					cur_valid_q                <= 1'b0;
					jobs_served_q[pick_idx_s2] <= jobs_inc;
					if (more_jobs) begin
						units_left_q[pick_idx_s2]   <= sel_exec;
						release_time_q[pick_idx_s2] <=
							edfs_pkg::sat_add_time(sel_release, sel_period);
						abs_deadline_q[pick_idx_s2] <=
							edfs_pkg::sat_add_time(sel_dl, sel_period);
					end else begin
						units_left_q[pick_idx_s2] <= units_dec;
					end
				end else begin
					units_left_q[pick_idx_s2] <= units_dec;
					cur_valid_q               <= 1'b1;
					cur_task_q                <= pick_idx_s2;
					cur_dl_q                  <= sel_dl;
				end
			end else begin
				cur_valid_q <= 1'b0;
				if (!all_done_s1) begin
					now_q <= now_inc;
				end
			end
		end
	end

	assign slot_time    = slot_time_q;
	assign granted_task = granted_q;
	assign idle         = idle_q;
	assign job_complete = job_complete_q;
	assign all_finished = all_finished_q;

	a_running_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (units_left_q[cur_task_q] != '0))
		else $error("running task has no units left");

	a_grant_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && !is_load && grant_s2) |-> (sel_units != '0))
		else $error("granted task has no units left");

	a_running_deadline: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_dl_q == abs_deadline_q[cur_task_q]))
		else $error("running deadline copy out of step");

endmodule

// ----- rtl/core/edf_periodic_task_scheduler.sv -----
// top level of the preemptive edf periodic task scheduler
// flow: a tick item runs the search, pick and update steps of the sequencer, a load item skips pick;
// a new item is taken only once the last one has left its update step, and a stalled result
// holds the next item in its update step
// reset: task table, time and running mark clear at once, task_count 1, jobs_per_task 2
module edf_periodic_task_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [edfs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [edfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic [edfs_pkg::TASK_W-1:0]         task_index,
	input  logic [edfs_pkg::EXEC_W-1:0]         exec_time,
	input  logic [edfs_pkg::EXEC_W-1:0]         period,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [edfs_pkg::TIME_W-1:0]         slot_time,
	output logic [edfs_pkg::TASK_W-1:0]         granted_task,
	output logic                                idle,
	output logic                                job_complete,
	output logic                                all_finished
);

	edfs_pkg::dp_cmd_t cmd;
	edfs_pkg::dp_sts_t sts;

	edfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	edfs_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.task_index   (task_index),
		.exec_time    (exec_time),
		.period       (period),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.slot_time    (slot_time),
		.granted_task (granted_task),
		.idle         (idle),
		.job_complete (job_complete),
		.all_finished (all_finished)
	);

endmodule

// ----- tb/tb_edf_periodic_task_scheduler.sv -----
// self-checking testbench for the edf periodic task scheduler: directed table, then random phases
module tb_edf_periodic_task_scheduler;
	import edfs_pkg::*;

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 1150;

	typedef struct packed {
		op_t                op;
		logic [TASK_W-1:0]  slot;
		logic [EXEC_W-1:0]  exec_t;
		logic [EXEC_W-1:0]  per;
	} sched_cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] start;
		logic [TASK_W-1:0] grant;
		logic              idl;
		logic              done_job;
		logic              all_done;
	} sched_res_t;

	typedef struct packed {
		logic                  is_cfg;
		logic [CFG_IDX_W-1:0]  reg_idx;
		logic [CFG_DATA_W-1:0] reg_val;
		sched_cmd_t            cmd;
		logic                  typed;
		sched_res_t            want;
	} stim_row_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  operation    = 1'b0;
	logic [TASK_W-1:0]     task_index   = '0;
	logic [EXEC_W-1:0]     exec_time    = '0;
	logic [EXEC_W-1:0]     period       = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [TIME_W-1:0]     slot_time;
	logic [TASK_W-1:0]     granted_task;
	logic                  idle;
	logic                  job_complete;
	logic                  all_finished;

	edf_periodic_task_scheduler dut (.*);

	// scheduler state as the predictor sees it
	logic [COUNT_W-1:0] p_tasks;
	logic [JOBS_W-1:0]  p_jobs;
	logic [EXEC_W-1:0]  p_exec [MAX_TASKS];
	logic [EXEC_W-1:0]  p_per [MAX_TASKS];
	logic [EXEC_W-1:0]  p_left [MAX_TASKS];
	logic [TIME_W-1:0]  p_rel [MAX_TASKS];
	logic [TIME_W-1:0]  p_dl [MAX_TASKS];
	logic [JOBS_W-1:0]  p_served [MAX_TASKS];
	logic [TIME_W-1:0]  p_now;
	logic [TASK_W-1:0]  p_run;
	logic               p_run_valid;

	sched_res_t due[$];
	sched_res_t head;
	int sent = 0;
	int snd_idle = 21;
	int rcv_idle = 61;
	int mismatches = 0;
	int quiet = 0;

	function automatic logic [TIME_W-1:0] time_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	function automatic int slots_used();
		return (p_tasks > MAX_TASKS) ? MAX_TASKS : int'(p_tasks);
	endfunction

	function automatic bit slot_ready(int i);
		return i < slots_used() && p_now >= p_rel[i] && p_left[i] != 0 && p_served[i] < p_jobs;
	endfunction

	function automatic bit every_task_done();
		for (int i = 0; i < slots_used(); i++) begin
			if (p_served[i] < p_jobs) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic sched_res_t edf_predict(sched_cmd_t c);
		sched_res_t r;
		int best;
		bit have;
		r = '0;
		r.start = p_now;
		if (c.op == OP_LOAD) begin
			p_exec[c.slot] = c.exec_t;
			p_per[c.slot] = c.per;
			p_left[c.slot] = c.exec_t;
			p_rel[c.slot] = '0;
			p_dl[c.slot] = {16'b0, c.per};
			p_served[c.slot] = '0;
			p_now = '0;
			p_run_valid = 1'b0;
			r.start = '0;
		end else if (every_task_done()) begin
			r.idl = 1'b1;
			p_run_valid = 1'b0;
		end else begin
			have = 1'b0;
			best = 0;
			for (int i = 0; i < slots_used(); i++) begin
				if (slot_ready(i) && (!have || p_dl[i] < p_dl[best])) begin
					have = 1'b1;
					best = i;
				end
			end
			// running task keeps the slot unless beaten strictly
			if (p_run_valid && slot_ready(p_run) && !(p_dl[best] < p_dl[p_run]))
				best = p_run;
			else if (!have)
				best = MAX_TASKS;
			p_now = time_add(p_now, 1);
			if (best == MAX_TASKS) begin
				r.idl = 1'b1;
				p_run_valid = 1'b0;
			end else begin
				r.grant = best[TASK_W-1:0];
				p_left[best] = p_left[best] - 1'b1;
				if (p_left[best] == 0) begin
					r.done_job = 1'b1;
					p_run_valid = 1'b0;
					if (p_served[best] != JOBS_MAX) p_served[best] = p_served[best] + 1'b1;
					if (p_served[best] < p_jobs) begin
						p_rel[best] = time_add(p_rel[best], {16'b0, p_per[best]});
						p_dl[best] = time_add(p_dl[best], {16'b0, p_per[best]});
						p_left[best] = p_exec[best];
					end
				end else begin
					p_run_valid = 1'b1;
					p_run = best[TASK_W-1:0];
				end
			end
		end
		r.all_done = every_task_done();
		return r;
	endfunction

	function automatic stim_row_t cmd_row(op_t op, int slot, int ex, int per);
		stim_row_t r;
		r = '0;
		r.cmd.op = op;
		r.cmd.slot = TASK_W'(slot);
		r.cmd.exec_t = EXEC_W'(ex);
		r.cmd.per = EXEC_W'(per);
		return r;
	endfunction

	function automatic stim_row_t known_row(op_t op, int slot, int ex, int per,
		int st, int g, bit idl, bit jc, bit af);
		stim_row_t r;
		r = cmd_row(op, slot, ex, per);
		r.typed = 1'b1;
		r.want = '{TIME_W'(st), TASK_W'(g), idl, jc, af};
		return r;
	endfunction

	function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, int val);
		stim_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.reg_idx = idx;
		r.reg_val = CFG_DATA_W'(val);
		return r;
	endfunction

	function automatic sched_cmd_t rand_load(int slot);
		sched_cmd_t c;
		c.op = OP_LOAD;
		c.slot = TASK_W'(slot);
		case ($urandom_range(15))
			0: c.exec_t = '0;
			1: c.exec_t = EXEC_W'($urandom);
			default: c.exec_t = EXEC_W'($urandom_range(1, 4));
		endcase
		case ($urandom_range(9))
			0: c.per = EXEC_W'($urandom);
			1: c.per = '0;
			default: c.per = EXEC_W'($urandom_range(1, 12));
		endcase
		return c;
	endfunction

	task automatic send_cmd(sched_cmd_t c, bit typed, sched_res_t want);
		sched_res_t r;
		if (sent < 400) begin
			snd_idle = 21;
			rcv_idle = 61;
		end else if (sent < 800) begin
			snd_idle = 61;
			rcv_idle = 21;
		end else begin
			snd_idle = 0;
			rcv_idle = 0;
		end
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= c.op;
		task_index <= c.slot;
		exec_time <= c.exec_t;
		period <= c.per;
		do @(posedge clk); while (!in_ready);
		r = edf_predict(c);
		due.push_back(typed ? want : r);
		sent++;
	endtask

	// registers change only with nothing in flight
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		in_valid <= 1'b0;
		while (due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_TASK_COUNT)
			p_tasks = val[COUNT_W-1:0];
		else
			p_jobs = val;
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (due.size() == 0) begin
				$error("result transfer with nothing pending, slot_time %0d", slot_time);
				mismatches++;
			end else begin
				head = due.pop_front();
				if (head.start !== slot_time) begin
					$error("slot_time: expected %0d, got %0d", head.start, slot_time);
					mismatches++;
				end
				if (head.grant !== granted_task) begin
					$error("granted_task: expected %0d, got %0d", head.grant, granted_task);
					mismatches++;
				end
				if (head.idl !== idle) begin
					$error("idle: expected %0d, got %0d", head.idl, idle);
					mismatches++;
				end
				if (head.done_job !== job_complete) begin
					$error("job_complete: expected %0d, got %0d", head.done_job, job_complete);
					mismatches++;
				end
				if (head.all_done !== all_finished) begin
					$error("all_finished: expected %0d, got %0d", head.all_done, all_finished);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		sched_cmd_t c;
		int dir_items;
		int pick;
		int tc;
		int jpt;
		int used;
		int n_load;
		int n_tick;
		bit broken;
		p_tasks = TASK_COUNT_RST;
		p_jobs = JOBS_PER_TASK_RST;
		for (int i = 0; i < MAX_TASKS; i++) begin
			p_exec[i] = '0;
			p_per[i] = '0;
			p_left[i] = '0;
			p_rel[i] = '0;
			p_dl[i] = '0;
			p_served[i] = '0;
		end
		p_now = '0;
		p_run = '0;
		p_run_valid = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		rows = '{
			known_row(OP_TICK, 0, 0, 0, 0, 0, 1, 0, 0),
			known_row(OP_LOAD, 0, 1, 2, 0, 0, 0, 0, 0),
			known_row(OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0),
			known_row(OP_TICK, 0, 0, 0, 1, 0, 1, 0, 0),
			known_row(OP_TICK, 0, 0, 0, 2, 0, 0, 1, 1),
			known_row(OP_TICK, 15, 65535, 65535, 3, 0, 1, 0, 1),
			reg_row(REG_TASK_COUNT, 16),
			reg_row(REG_JOBS_PER_TASK, 255),
			known_row(OP_LOAD, 15, 65535, 65535, 0, 0, 0, 0, 0),
			known_row(OP_LOAD, 15, 0, 0, 0, 0, 0, 0, 0),
			reg_row(REG_TASK_COUNT, 3),
			reg_row(REG_JOBS_PER_TASK, 2),
			// short-deadline task preempts, equal deadlines go to the lower slot
			cmd_row(OP_LOAD, 0, 3, 12),
			cmd_row(OP_LOAD, 1, 2, 3),
			cmd_row(OP_LOAD, 2, 1, 12),
			cmd_row(OP_TICK, 0, 0, 0),
			cmd_row(OP_TICK, 0, 0, 0),
			cmd_row(OP_TICK, 0, 0, 0),
			cmd_row(OP_TICK, 0, 0, 0),
			cmd_row(OP_TICK, 15, 65535, 65535),
			cmd_row(OP_TICK, 0, 0, 0),
			cmd_row(OP_TICK, 0, 0, 0),
			cmd_row(OP_TICK, 0, 0, 0),
			reg_row(REG_TASK_COUNT, 0),
			known_row(OP_LOAD, 7, 5, 5, 0, 0, 0, 0, 1),
			known_row(OP_TICK, 0, 0, 0, 0, 0, 1, 0, 1),
			reg_row(REG_TASK_COUNT, 31),
			reg_row(REG_JOBS_PER_TASK, 0),
			known_row(OP_LOAD, 5, 2, 3, 0, 0, 0, 0, 1),
			known_row(OP_TICK, 0, 0, 0, 0, 0, 1, 0, 1)
		};
		foreach (rows[k]) begin
			if (rows[k].is_cfg)
				write_reg(rows[k].reg_idx, rows[k].reg_val);
			else
				send_cmd(rows[k].cmd, rows[k].typed, rows[k].want);
		end
		dir_items = sent;

		while (sent < dir_items + RANDOM_ITEMS) begin
			pick = $urandom_range(19);
			if (pick < 3)
				tc = 16;
			else if (pick == 3)
				tc = 0;
			else if (pick == 4)
				tc = $urandom_range(17, 31);
			else
				tc = $urandom_range(1, 6);
			pick = $urandom_range(9);
			if (pick == 0)
				jpt = 255;
			else if (pick == 1)
				jpt = 0;
			else
				jpt = $urandom_range(1, 4);
			write_reg(REG_TASK_COUNT, CFG_DATA_W'(tc));
			write_reg(REG_JOBS_PER_TASK, CFG_DATA_W'(jpt));
			used = (tc > MAX_TASKS) ? MAX_TASKS : tc;
			n_load = (used == 0) ? 1 : used;
			// a broken set leaves some slots with stale state
			broken = ($urandom_range(4) == 0);
			for (int s = 0; s < n_load; s++) begin
				if (!broken || $urandom_range(1) == 1)
					send_cmd(rand_load((used == 0) ? $urandom_range(15) : s), 1'b0, '0);
			end
			n_tick = $urandom_range(20, 60);
			for (int j = 0; j < n_tick; j++) begin
				if ($urandom_range(11) == 0) begin
					c = rand_load($urandom_range(15));
				end else begin
					c.op = OP_TICK;
					c.slot = TASK_W'($urandom_range(15));
					c.exec_t = EXEC_W'($urandom);
					c.per = EXEC_W'($urandom);
				end
				send_cmd(c, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/edfs_pkg.sv
rtl/core/edfs_ctrl.sv
rtl/core/edfs_dpath.sv
rtl/core/edf_periodic_task_scheduler.sv
tb/tb_edf_periodic_task_scheduler.sv
